### design/mnsq_pkg.sv
// mnsq_pkg: shared types, codes and tables for the midi note scale quantizer
// holds the scale mask rom, pitch-class helpers and configuration codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mnsq_pkg;

  localparam int PITCH_CLASSES = 12;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_INDEX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_NOTE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_SELECT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_MODE    = 2'd2;

  // snap modes, any other code behaves as nearest
  localparam logic [1:0] SNAP_NEAREST = 2'd0;
  localparam logic [1:0] SNAP_DOWN    = 2'd1;
  localparam logic [1:0] SNAP_UP      = 2'd2;

  // message types in the status high nibble
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

  typedef struct packed {
    logic [3:0] root_note;
    logic [4:0] scale_select;
    logic [1:0] snap_mode;
  } cfg_t;

  // bit k set: pitch class k above the root is in the scale
  function automatic logic [11:0] scale_mask(input logic [4:0] idx);
    logic [11:0] m;
    case (idx)
      5'd0:    m = 12'hAB5;
      5'd1:    m = 12'h5AD;
      5'd2:    m = 12'h9AD;
      5'd3:    m = 12'hAAD;
      5'd4:    m = 12'h6AD;
      5'd5:    m = 12'h5AB;
      5'd6:    m = 12'hAD5;
      5'd7:    m = 12'h6B5;
      5'd8:    m = 12'h56B;
      5'd9:    m = 12'h295;
      5'd10:   m = 12'h4A9;
      5'd11:   m = 12'h4E9;
      5'd12:   m = 12'hFFF;
      5'd13:   m = 12'hAB5;
      5'd14:   m = 12'hAD5;
      5'd15:   m = 12'h6B5;
      5'd16:   m = 12'h9B3;
      5'd17:   m = 12'h9D3;
      5'd18:   m = 12'hAD3;
      5'd19:   m = 12'h6AD;
      5'd20:   m = 12'h5AD;
      5'd21:   m = 12'h5AB;
      5'd22:   m = 12'h9CB;
      5'd23:   m = 12'h295;
      5'd24:   m = 12'h529;
      5'd25:   m = 12'h895;
      5'd26:   m = 12'h5B5;
      5'd27:   m = 12'h9AD;
      default: m = 12'hFFF;
    endcase
    return m;
  endfunction

  // value mod 12 for values below 256, by reciprocal multiply
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    prod = {8'd0, v} * 16'd171;
    q    = prod[15:11];
    rem  = v - 8'(q * 4'd12);
    return rem[3:0];
  endfunction

  // index of the highest set bit, 0 when none
  function automatic logic [3:0] msb_index(input logic [11:0] m);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 0; k < PITCH_CLASSES; k++) begin
      if (m[k]) idx = 4'(k);
    end
    return idx;
  endfunction

  // index of the lowest set bit, 0 when none
  function automatic logic [3:0] lsb_index(input logic [11:0] m);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = PITCH_CLASSES - 1; k >= 0; k--) begin
      if (m[k]) idx = 4'(k);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### design/mnsq_snap.sv
// mnsq_snap: combinational note snapping to the selected scale
// finds the nearest scale tones below and above, wrapping the octave, and clamps
// depends on mnsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnsq_snap (
  input  wire mnsq_pkg::cfg_t cfg,
  input  wire logic [6:0]     note,
  output logic [6:0]          snapped
);
  import mnsq_pkg::*;

  logic [11:0] mask;
  logic [7:0]  shifted;
  logic [3:0]  pc;
  logic [11:0] pc_bit;
  logic [11:0] lo_mask;
  logic [11:0] hi_mask;
  logic [11:0] above_bits;
  logic        in_scale;
  logic [4:0]  dn_wide;
  logic [4:0]  up_wide;
  logic [3:0]  dn;
  logic [3:0]  up;
  logic        go_down;
  logic [7:0]  up_sum;

  always_comb begin
    mask     = scale_mask(cfg.scale_select);
    shifted  = {1'b0, note} + 8'd24 - {4'd0, cfg.root_note};
    pc       = mod12(shifted);
    pc_bit   = 12'd1 << pc;
    in_scale = |(mask & pc_bit);
    lo_mask  = mask & (pc_bit - 12'd1);
    // above_bits covers classes up to pc; hi_mask keeps those strictly above, empty when pc is eleven
    above_bits = (pc_bit << 1) - 12'd1;
    hi_mask  = mask & ~above_bits;

    if (|lo_mask) dn_wide = {1'b0, pc} - {1'b0, msb_index(lo_mask)};
    else          dn_wide = {1'b0, pc} + 5'd12 - {1'b0, msb_index(mask)};
    if (|hi_mask) up_wide = {1'b0, lsb_index(hi_mask)} - {1'b0, pc};
    else          up_wide = {1'b0, lsb_index(mask)} + 5'd12 - {1'b0, pc};
    dn = dn_wide[3:0];
    up = up_wide[3:0];

    case (cfg.snap_mode)
      SNAP_DOWN: go_down = 1'b1;
      SNAP_UP:   go_down = 1'b0;
      default:   go_down = (dn <= up);
    endcase

    up_sum = {1'b0, note} + {4'd0, up};

    if (in_scale) begin
      snapped = note;
    end else if (go_down) begin
      snapped = (note < {3'd0, dn}) ? 7'd0 : note - {3'd0, dn};
    end else begin
      snapped = up_sum[7] ? 7'd127 : up_sum[6:0];
    end
  end

endmodule

`default_nettype wire

### design/midi_note_scale_quantizer.sv
// midi_note_scale_quantizer: top level with config registers and item pipeline
// depends on mnsq_pkg and mnsq_snap
`timescale 1ns / 1ps
`default_nettype none

// Takes one three-byte MIDI channel message per item and returns one item with
// note-on and note-off notes snapped to the scale chosen by root_note,
// scale_select and snap_mode; note-on with velocity zero and note-off both come
// out as 0x8n with velocity zero, all other messages pass unchanged. Throughput
// is one item per clock cycle while out_stall is low. The input register captures
// an item on acceptance, the combinational snap logic between the two registers
// works on it, and the result register then loads the result and raises out_valid
// unless the output is stalled; the result leaves when out_stall is low.
// in_stall rises only when both registers hold items and out_stall is high.
// Configuration is written through write_enable, write_index and write_data;
// write it only while no item is in flight.
module midi_note_scale_quantizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            write_enable,
  input  wire logic [mnsq_pkg::CFG_INDEX_W-1:0] write_index,
  input  wire logic [mnsq_pkg::CFG_DATA_W-1:0]  write_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      status_byte,
  input  wire logic [6:0]                      first_data,
  input  wire logic [6:0]                      second_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_status,
  output logic [6:0]                           out_first_data,
  output logic [6:0]                           out_second_data
);
  import mnsq_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_status;
  logic [6:0] s1_first;
  logic [6:0] s1_second;
  logic       s2_ready;
  logic       s1_ready;
  logic [6:0] snapped;
  logic [3:0] s1_type;
  logic [7:0] status_next;
  logic [6:0] first_next;
  logic [6:0] second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_enable) begin
      unique case (write_index)
        CFG_ROOT_NOTE:    cfg.root_note    <= write_data[3:0];
        CFG_SCALE_SELECT: cfg.scale_select <= write_data[4:0];
        CFG_SNAP_MODE:    cfg.snap_mode    <= write_data[1:0];
        default:          ;
      endcase
    end
  end

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_status <= status_byte;
      s1_first  <= first_data;
      s1_second <= second_data;
    end
  end

  mnsq_snap u_snap (
    .cfg     (cfg),
    .note    (s1_first),
    .snapped (snapped)
  );

  assign s1_type = s1_status[7:4];

  always_comb begin
    if (s1_type == MSG_NOTE_ON && s1_second != 7'd0) begin
      status_next = {MSG_NOTE_ON, s1_status[3:0]};
      first_next  = snapped;
      second_next = s1_second;
    end else if (s1_type == MSG_NOTE_ON || s1_type == MSG_NOTE_OFF) begin
      status_next = {MSG_NOTE_OFF, s1_status[3:0]};
      first_next  = snapped;
      second_next = 7'd0;
    end else begin
      status_next = s1_status;
      first_next  = s1_first;
      second_next = s1_second;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      out_status      <= status_next;
      out_first_data  <= first_next;
      out_second_data <= second_next;
    end
  end

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled while pipeline has room");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted item not held in input register");

  a_note_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status[7:4] == MSG_NOTE_OFF) |-> (out_second_data == 7'd0))
    else $error("note-off item with nonzero velocity");

  a_note_on_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status[7:4] == MSG_NOTE_ON) |-> (out_second_data != 7'd0))
    else $error("note-on item with zero velocity");

endmodule

`default_nettype wire

### test/note_snap_checker.sv
// note_snap_checker: watches the quantizer channels, predicts each result and compares
// depends on mnsq_pkg for the register indexes, snap modes and message types
`timescale 1ns / 1ps

module note_snap_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [mnsq_pkg::CFG_INDEX_W-1:0]  write_index,
  input  logic [mnsq_pkg::CFG_DATA_W-1:0]   write_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        status_byte,
  input  logic [6:0]                        first_data,
  input  logic [6:0]                        second_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [7:0]                        out_status,
  input  logic [6:0]                        out_first_data,
  input  logic [6:0]                        out_second_data,
  output int                                errors,
  output int                                pending,
  output int                                checked
);
  import mnsq_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } midi_msg_t;

  // pitch-class masks, entry 0 in the low 12 bits; 28..31 are chromatic
  localparam logic [32*12-1:0] MASK_TABLE = {
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h9AD, 12'h5B5, 12'h895, 12'h529,
    12'h295, 12'h9CB, 12'h5AB, 12'h5AD, 12'h6AD, 12'hAD3, 12'h9D3, 12'h9B3,
    12'h6B5, 12'hAD5, 12'hAB5, 12'hFFF, 12'h4E9, 12'h4A9, 12'h295, 12'h56B,
    12'h6B5, 12'hAD5, 12'h5AB, 12'h6AD, 12'hAAD, 12'h9AD, 12'h5AD, 12'hAB5
  };

  cfg_t      cfg;
  midi_msg_t quantized_q[$];

  function automatic logic [6:0] snapped_note(input logic [6:0] note, input cfg_t c);
    logic [11:0] mask;
    int pc, lo, hi, pick, res;
    mask = MASK_TABLE[int'(c.scale_select) * 12 +: 12];
    pc = (int'(note) + 24 - int'(c.root_note)) % 12;
    if (mask[pc]) return note;
    lo = -1000;
    hi = 1000;
    for (int k = 0; k < 12; k++) begin
      if (mask[k]) begin
        if (k < pc) lo = k;
        if (k > pc && hi == 1000) hi = k;
      end
    end
    // wrap around the octave when no tone lies on one side
    if (lo == -1000) begin
      for (int k = 0; k < 12; k++) if (mask[k]) lo = k - 12;
    end
    if (hi == 1000) begin
      for (int k = 11; k >= 0; k--) if (mask[k]) hi = k + 12;
    end
    case (c.snap_mode)
      SNAP_DOWN: pick = lo;
      SNAP_UP:   pick = hi;
      default:   pick = (pc - lo <= hi - pc) ? lo : hi;
    endcase
    res = int'(note) + pick - pc;
    if (res < 0) res = 0;
    if (res > 127) res = 127;
    return 7'(res);
  endfunction

  function automatic midi_msg_t quantized_msg(input midi_msg_t m, input cfg_t c);
    midi_msg_t r;
    logic [3:0] kind;
    kind = m.status[7:4];
    r = m;
    if (kind == MSG_NOTE_ON && m.data2 != 7'd0) begin
      r.data1 = snapped_note(m.data1, c);
    end else if (kind == MSG_NOTE_ON || kind == MSG_NOTE_OFF) begin
      r.status = {MSG_NOTE_OFF, m.status[3:0]};
      r.data1  = snapped_note(m.data1, c);
      r.data2  = 7'd0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    midi_msg_t want;
    if (rst) begin
      quantized_q.delete();
      cfg = '0;
      errors = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (write_enable) begin
        case (write_index)
          CFG_ROOT_NOTE:    cfg.root_note = write_data[3:0];
          CFG_SCALE_SELECT: cfg.scale_select = write_data[4:0];
          CFG_SNAP_MODE:    cfg.snap_mode = write_data[1:0];
          default: ;
        endcase
      end
      // pop before push so a fresh item never matches its own result
      if (out_valid && !out_stall) begin
        if (quantized_q.size() == 0) begin
          $display("%0t: unexpected item %02h %02h %02h", $time,
                   out_status, out_first_data, out_second_data);
          errors++;
        end else begin
          want = quantized_q.pop_front();
          checked++;
          if (out_status !== want.status) begin
            $display("%0t: out_status expected %02h got %02h", $time,
                     want.status, out_status);
            errors++;
          end
          if (out_first_data !== want.data1) begin
            $display("%0t: out_first_data expected %0d got %0d", $time,
                     want.data1, out_first_data);
            errors++;
          end
          if (out_second_data !== want.data2) begin
            $display("%0t: out_second_data expected %0d got %0d", $time,
                     want.data2, out_second_data);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        quantized_q.push_back(quantized_msg({status_byte, first_data, second_data}, cfg));
      end
      pending = quantized_q.size();
    end
  end

endmodule

### test/tb_midi_note_scale_quantizer.sv
// tb_midi_note_scale_quantizer: drives messages and register settings into the quantizer
// depends on mnsq_pkg, midi_note_scale_quantizer and note_snap_checker
`timescale 1ns / 1ps

module tb_midi_note_scale_quantizer;
  import mnsq_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0]  write_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             status_byte;
  logic [6:0]             first_data;
  logic [6:0]             second_data;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_status;
  logic [6:0]             out_first_data;
  logic [6:0]             out_second_data;

  int errors, pending, checked;
  int n_items, n_notes, n_settings;
  logic calm;

  midi_note_scale_quantizer uut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .status_byte(status_byte), .first_data(first_data), .second_data(second_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_first_data(out_first_data),
    .out_second_data(out_second_data)
  );

  note_snap_checker checker_i (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .status_byte(status_byte), .first_data(first_data), .second_data(second_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_first_data(out_first_data),
    .out_second_data(out_second_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // all tasks start and end on a falling edge
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    write_enable = 1'b1;
    write_index  = idx;
    write_data   = val;
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input int root, input int scale, input int mode);
    drain();
    set_reg(CFG_ROOT_NOTE, CFG_DATA_W'(root));
    set_reg(CFG_SCALE_SELECT, CFG_DATA_W'(scale));
    set_reg(CFG_SNAP_MODE, CFG_DATA_W'(mode));
    n_settings++;
  endtask

  task automatic send_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    = 1'b1;
    status_byte = st;
    first_data  = d1;
    second_data = d2;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_items++;
    if (st[7:4] == MSG_NOTE_ON || st[7:4] == MSG_NOTE_OFF) n_notes++;
  endtask

  // mostly note traffic, some arbitrary bytes
  task automatic send_random;
    logic [3:0] chan;
    logic [6:0] note, vel;
    int sel;
    chan = 4'($urandom_range(0, 15));
    sel  = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) note = $urandom_range(0, 1) ? 7'd127 : 7'd0;
    else note = 7'($urandom_range(0, 127));
    vel = 7'($urandom_range(0, 127));
    if (sel <= 3) send_msg({MSG_NOTE_ON, chan}, note, 7'($urandom_range(1, 127)));
    else if (sel <= 5) send_msg({MSG_NOTE_OFF, chan}, note, vel);
    else if (sel == 6) send_msg({MSG_NOTE_ON, chan}, note, 7'd0);
    else send_msg(8'($urandom_range(0, 255)), note, vel);
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    in_valid = 1'b0;
    status_byte = '0;
    first_data = '0;
    second_data = '0;
    n_items = 0;
    n_notes = 0;
    n_settings = 1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // reset setting: C major, nearest
    send_msg({MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127);
    send_msg({MSG_NOTE_ON, 4'hF}, 7'd127, 7'd1);
    send_msg({MSG_NOTE_ON, 4'h0}, 7'd61, 7'd64);   // tie between two tones goes down
    send_msg({MSG_NOTE_ON, 4'h3}, 7'd63, 7'd0);    // velocity zero becomes note-off
    send_msg({MSG_NOTE_OFF, 4'h5}, 7'd66, 7'd100); // note-off velocity cleared
    send_msg(8'hB0, 7'd7, 7'd127);
    send_msg(8'h40, 7'd60, 7'd60);                 // data byte in the status slot
    send_msg(8'hF8, 7'd0, 7'd0);
    send_msg(8'hFF, 7'd127, 7'd127);
    send_msg(8'hE3, 7'd0, 7'd0);

    // B pentatonic, snap up: top clamp and wrap past the highest tone
    apply_setting(11, 9, SNAP_UP);
    send_msg({MSG_NOTE_ON, 4'h1}, 7'd127, 7'd90);
    send_msg({MSG_NOTE_OFF, 4'h1}, 7'd0, 7'd0);
    send_msg({MSG_NOTE_ON, 4'h2}, 7'd9, 7'd33);

    apply_setting(11, 9, SNAP_DOWN);
    send_msg({MSG_NOTE_ON, 4'h1}, 7'd0, 7'd90);    // snaps below zero and clamps
    send_msg({MSG_NOTE_ON, 4'h1}, 7'd125, 7'd10);
    send_msg({MSG_NOTE_OFF, 4'h7}, 7'd9, 7'd127);

    // root above eleven, unknown snap code, chromatic slots
    apply_setting(15, 0, 3);
    send_msg({MSG_NOTE_ON, 4'h0}, 7'd61, 7'd50);
    send_msg({MSG_NOTE_ON, 4'h0}, 7'd62, 7'd50);
    apply_setting(4, 31, SNAP_DOWN);
    send_msg({MSG_NOTE_ON, 4'h8}, 7'd61, 7'd50);
    apply_setting(0, 12, SNAP_UP);
    send_msg({MSG_NOTE_OFF, 4'h8}, 7'd66, 7'd5);
    apply_setting(0, 27, SNAP_NEAREST);
    send_msg({MSG_NOTE_ON, 4'h9}, 7'd127, 7'd127);
    send_msg({MSG_NOTE_ON, 4'h9}, 7'd1, 7'd127);

    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 3) == 0) apply_setting($urandom_range(0, 15), $urandom_range(0, 31),
                                                   $urandom_range(0, 3));
      else apply_setting($urandom_range(0, 11), $urandom_range(0, 27), $urandom_range(0, 2));
      // last phase runs without any idling
      calm = (ph == 9);
      repeat (50) send_random();
    end

    drain();
    $display("sent %0d items (%0d note messages) under %0d register settings",
             n_items, n_notes, n_settings);
    $display("checked %0d results, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
